### sv/assert_macros.svh
// assertion helpers shared by the serializer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define LTS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/lts_pkg.sv
package lts_pkg;

  // token kinds carried on in_tuser
  typedef enum logic [1:0] {
    OP_LITERAL = 2'd0,
    OP_MATCH   = 2'd1,
    OP_END     = 2'd2
  } opcode_t;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CHUNK_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS     = 1'd1;
  localparam int CFG_DATA_W = 16;

  localparam int OUT_ADDR_W  = 16;
  localparam int MAX_WRITES  = 5;
  localparam int WCNT_W      = $clog2(MAX_WRITES + 1);
  localparam int QUEUE_DEPTH = 2;

  // one byte write
  typedef struct packed {
    logic                  we;
    logic [7:0]            data;
    logic [OUT_ADDR_W-1:0] addr;
  } wr_t;

  // all writes caused by one token, slot 0 goes out first
  typedef struct packed {
    logic [WCNT_W-1:0]           count;
    wr_t [MAX_WRITES-1:0]        wr;
  } cmd_t;

endpackage

### sv/lzss_token_serializer_top.sv
// lzss token serializer: turns literal, match and end tokens into byte writes for a
// byte-addressed memory, with a flag byte reserved ahead of every FLAG_BITS chunks
// and matches, literal chunks behind a patched length byte and matches as distance
// low, distance high, length. the front stage takes one token per cycle and works
// out all of its writes at once; a two-entry command queue sits between it and the
// back stage, which puts out one write per cycle while out_tready is high. a token
// makes one write for a literal inside a chunk or an end marker, two or three for a
// literal that opens or closes a chunk, four or five for a match. the output port's
// one write per cycle sets the sustained rate; the input stalls only when the queue
// is full. a command is registered in the queue, then in the back stage.
// configuration must be written while nothing is in flight; this is not enforced.
module lzss_token_serializer_top #(
  parameter int FLAG_BITS     = 8,   // chunks and matches described by one flag byte, 1 to 8
  parameter int ADDRESS_WIDTH = 16   // width of the internal address arithmetic
) (
  input  logic        clk,
  input  logic        rst_n,

  // token input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // literal_byte [7:0], match_distance [23:8],
                                   // match_length [31:24]
  input  logic [1:0]  in_tuser,    // opcode [1:0]

  // byte write output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // write_address [15:0], write_data [23:16]
  output logic        out_tuser,   // write_enable [0]
  output logic        out_tlast,   // final write of a token

  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lts_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lts_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lts_pkg::*;

  logic [7:0]            max_chunk_length_r;
  logic [OUT_ADDR_W-1:0] base_address_r;

  logic                  in_fire;
  logic                  q_full;
  logic                  q_push;
  cmd_t                  q_push_cmd;
  logic                  q_pop;
  logic                  q_valid;
  cmd_t                  q_cmd;
  logic [OUT_ADDR_W-1:0] wr_addr;
  logic [7:0]            wr_data;

  // registers are always ready to take a transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chunk_length_r <= 8'd255;
      base_address_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_CHUNK_LENGTH: max_chunk_length_r <= cfg_data[7:0];
        CFG_BASE_ADDRESS:     base_address_r     <= cfg_data[OUT_ADDR_W-1:0];
        default:              max_chunk_length_r <= max_chunk_length_r;
      endcase
    end
  end

  // input is ready whenever the queue has room
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  lts_front #(
    .FLAG_BITS     (FLAG_BITS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept_i           (in_fire),
    .opcode_i           (in_tuser),
    .literal_byte_i     (in_tdata[7:0]),
    .match_distance_i   (in_tdata[23:8]),
    .match_length_i     (in_tdata[31:24]),
    .max_chunk_length_i (max_chunk_length_r),
    .base_address_i     (base_address_r),
    .push_o             (q_push),
    .cmd_o              (q_push_cmd)
  );

  lts_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  lts_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_tvalid),
    .out_ready_i     (out_tready),
    .write_address_o (wr_addr),
    .write_data_o    (wr_data),
    .write_enable_o  (out_tuser),
    .last_o          (out_tlast)
  );

  assign out_tdata = {wr_data, wr_addr};

endmodule

### sv/lts_fifo.sv
`include "assert_macros.svh"

module lts_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  lts_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lts_pkg::cmd_t pop_cmd_o
);
  import lts_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full_o    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid_o   = (count_r != '0);
  assign pop_cmd_o = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push_i) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wptr_r] <= push_cmd_i;
    end
  end

  `LTS_ASSERT_NEVER(a_no_overflow, clk, rst_n, push_i && full_o, "push into full queue")
  `LTS_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop_i && !valid_o, "pop from empty queue")

endmodule

### sv/lts_front.sv
module lts_front #(
  parameter int FLAG_BITS     = 8,
  parameter int ADDRESS_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept_i,
  input  logic [1:0]                        opcode_i,
  input  logic [7:0]                        literal_byte_i,
  input  logic [15:0]                       match_distance_i,
  input  logic [7:0]                        match_length_i,
  input  logic [7:0]                        max_chunk_length_i,
  input  logic [lts_pkg::OUT_ADDR_W-1:0]    base_address_i,
  output logic                              push_o,
  output lts_pkg::cmd_t                     cmd_o
);
  import lts_pkg::*;

  localparam int AW    = ADDRESS_WIDTH;
  localparam int FBP_W = $clog2(FLAG_BITS + 1);

  logic [AW-1:0]    write_offset_r, write_offset_nxt;
  logic [AW-1:0]    flag_address_r, flag_address_nxt;
  logic [7:0]       flag_value_r, flag_value_nxt;
  logic [FBP_W-1:0] flag_bit_pos_r, flag_bit_pos_nxt;
  logic             chunk_open_r, chunk_open_nxt;
  logic [7:0]       chunk_count_r, chunk_count_nxt;
  logic [AW-1:0]    chunk_len_addr_r, chunk_len_addr_nxt;

  logic [AW-1:0] base_ext;
  logic [AW-1:0] addr_k [4];
  logic          need_flag;
  logic [7:0]    max_len;
  logic [7:0]    count_inc;
  logic [7:0]    flag_set;
  logic [2:0]    slot;
  logic [1:0]    aidx;
  opcode_t       opcode;

  function automatic logic [OUT_ADDR_W-1:0] to_out(input logic [AW-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[OUT_ADDR_W-1:0];
  endfunction

  function automatic wr_t mk(input logic [AW-1:0] a, input logic [7:0] d);
    wr_t w;
    w.we   = 1'b1;
    w.data = d;
    w.addr = to_out(a);
    return w;
  endfunction

  assign base_ext  = AW'(base_address_i);
  assign opcode    = opcode_t'(opcode_i);
  assign need_flag = (flag_bit_pos_r >= FBP_W'(FLAG_BITS));
  assign max_len   = (max_chunk_length_i == 8'd0) ? 8'd1 : max_chunk_length_i;
  assign count_inc = chunk_count_r + 8'd1;
  assign flag_set  = need_flag ? 8'd1 : (flag_value_r | (8'd1 << flag_bit_pos_r));

  // addresses of the next four bytes of the stream
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      addr_k[k] = base_ext + write_offset_r + AW'(k);
    end
  end

  always_comb begin
    write_offset_nxt   = write_offset_r;
    flag_address_nxt   = flag_address_r;
    flag_value_nxt     = flag_value_r;
    flag_bit_pos_nxt   = flag_bit_pos_r;
    chunk_open_nxt     = chunk_open_r;
    chunk_count_nxt    = chunk_count_r;
    chunk_len_addr_nxt = chunk_len_addr_r;
    cmd_o  = '0;
    push_o = 1'b0;
    slot   = '0;
    aidx   = '0;
    if (accept_i) begin
      case (opcode)
        OP_LITERAL: begin
          push_o = 1'b1;
          if (!chunk_open_r) begin
            if (need_flag) begin
              // fresh flag byte, literal bit is zero so no rewrite later
              cmd_o.wr[0]      = mk(addr_k[0], 8'd0);
              flag_address_nxt = addr_k[0];
              flag_value_nxt   = 8'd0;
              flag_bit_pos_nxt = FBP_W'(1);
              slot = 3'd1;
              aidx = 2'd1;
            end else begin
              flag_bit_pos_nxt = flag_bit_pos_r + FBP_W'(1);
            end
            cmd_o.wr[slot]          = mk(addr_k[aidx], 8'd1);
            cmd_o.wr[slot + 3'd1]   = mk(addr_k[aidx + 2'd1], literal_byte_i);
            cmd_o.count             = WCNT_W'(slot + 3'd2);
            chunk_len_addr_nxt      = addr_k[aidx];
            write_offset_nxt        = write_offset_r + AW'(aidx + 2'd2);
            chunk_count_nxt         = 8'd1;
            chunk_open_nxt          = (8'd1 < max_len);
          end else begin
            cmd_o.wr[0]      = mk(addr_k[0], literal_byte_i);
            cmd_o.count      = WCNT_W'(1);
            write_offset_nxt = write_offset_r + AW'(1);
            chunk_count_nxt  = count_inc;
            if (count_inc >= max_len) begin
              // chunk full: patch its length byte
              cmd_o.wr[1]    = mk(chunk_len_addr_r, count_inc);
              cmd_o.count    = WCNT_W'(2);
              chunk_open_nxt = 1'b0;
            end
          end
        end
        OP_MATCH: begin
          push_o = 1'b1;
          if (chunk_open_r) begin
            cmd_o.wr[0]    = mk(chunk_len_addr_r, chunk_count_r);
            chunk_open_nxt = 1'b0;
            slot = 3'd1;
          end
          if (need_flag) begin
            cmd_o.wr[slot]   = mk(addr_k[0], flag_set);
            flag_address_nxt = addr_k[0];
            flag_bit_pos_nxt = FBP_W'(1);
            aidx = 2'd1;
          end else begin
            cmd_o.wr[slot]   = mk(flag_address_r, flag_set);
            flag_bit_pos_nxt = flag_bit_pos_r + FBP_W'(1);
          end
          flag_value_nxt = flag_set;
          cmd_o.wr[slot + 3'd1] = mk(addr_k[aidx], match_distance_i[7:0]);
          cmd_o.wr[slot + 3'd2] = mk(addr_k[aidx + 2'd1], match_distance_i[15:8]);
          cmd_o.wr[slot + 3'd3] = mk(addr_k[aidx + 2'd2], match_length_i);
          cmd_o.count           = WCNT_W'(slot + 3'd4);
          write_offset_nxt      = write_offset_r + AW'(aidx + 2'd3);
        end
        OP_END: begin
          push_o      = 1'b1;
          cmd_o.count = WCNT_W'(1);
          if (chunk_open_r) begin
            cmd_o.wr[0] = mk(chunk_len_addr_r, chunk_count_r);
          end
          // stream state back to its reset values
          write_offset_nxt   = '0;
          flag_address_nxt   = '0;
          flag_value_nxt     = 8'd0;
          flag_bit_pos_nxt   = FBP_W'(FLAG_BITS);
          chunk_open_nxt     = 1'b0;
          chunk_count_nxt    = 8'd0;
          chunk_len_addr_nxt = '0;
        end
        default: begin
          // unused opcode: dropped without effect
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_offset_r   <= '0;
      flag_address_r   <= '0;
      flag_value_r     <= 8'd0;
      flag_bit_pos_r   <= FBP_W'(FLAG_BITS);
      chunk_open_r     <= 1'b0;
      chunk_count_r    <= 8'd0;
      chunk_len_addr_r <= '0;
    end else begin
      write_offset_r   <= write_offset_nxt;
      flag_address_r   <= flag_address_nxt;
      flag_value_r     <= flag_value_nxt;
      flag_bit_pos_r   <= flag_bit_pos_nxt;
      chunk_open_r     <= chunk_open_nxt;
      chunk_count_r    <= chunk_count_nxt;
      chunk_len_addr_r <= chunk_len_addr_nxt;
    end
  end

endmodule

### sv/lts_back.sv
`include "assert_macros.svh"

module lts_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid_i,
  input  lts_pkg::cmd_t                  q_cmd_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lts_pkg::OUT_ADDR_W-1:0] write_address_o,
  output logic [7:0]                     write_data_o,
  output logic                           write_enable_o,
  output logic                           last_o
);
  import lts_pkg::*;

  cmd_t              cur_r;
  logic              cur_valid_r, cur_valid_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              out_fire;
  logic              is_last;
  logic              load;
  wr_t               cur_wr;

  assign cur_wr   = cur_r.wr[idx_r];
  assign out_fire = cur_valid_r && out_ready_i;
  assign is_last  = (idx_r == 3'(cur_r.count - WCNT_W'(1)));
  assign load     = !cur_valid_r || (out_fire && is_last);
  assign q_pop_o  = load && q_valid_i;

  assign out_valid_o     = cur_valid_r;
  assign write_address_o = cur_wr.addr;
  assign write_data_o    = cur_wr.data;
  assign write_enable_o  = cur_wr.we;
  assign last_o          = is_last;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_valid_nxt = q_valid_i;
      idx_nxt       = 3'd0;
    end else if (out_fire) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      cur_r <= q_cmd_i;
    end
  end

  `LTS_ASSERT(a_count_range, clk, rst_n, cur_valid_r |-> (cur_r.count != '0 && cur_r.count <= WCNT_W'(MAX_WRITES)), "command write count out of range")
  `LTS_ASSERT(a_mid_cmd_step, clk, rst_n, (out_fire && !is_last) |=> (cur_valid_r && idx_r == $past(idx_r) + 3'd1), "command dropped before its last write")

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lts_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int TOKENS_PER_FLAG = 8;
  localparam int MAX_GAP         = 12;
  // well past the input-to-write latency
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 80;
  // opcode with no token kind behind it, the block drops it
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // one byte write as seen on the output port
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        we;
    logic        last;
  } mem_write_t;

  // predicts the writes of every accepted token and checks them in order
  class write_scoreboard;
    logic [7:0]  chunk_limit;
    logic [15:0] stream_base;
    logic [15:0] stream_offset;
    logic [15:0] flag_addr;
    logic [7:0]  flag_bits;
    int unsigned flag_slot;
    bit          chunk_active;
    logic [7:0]  chunk_len;
    logic [15:0] chunk_len_addr;
    mem_write_t  staged[$];
    mem_write_t  expected_writes[$];
    int unsigned mismatches;
    int unsigned writes_checked;
    int unsigned literal_tokens, match_tokens, end_tokens, ignored_tokens;

    function new();
      chunk_limit    = 8'd255;
      stream_base    = '0;
      mismatches     = 0;
      writes_checked = 0;
      literal_tokens = 0;
      match_tokens   = 0;
      end_tokens     = 0;
      ignored_tokens = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      stream_offset  = '0;
      flag_addr      = '0;
      flag_bits      = '0;
      flag_slot      = TOKENS_PER_FLAG;
      chunk_active   = 1'b0;
      chunk_len      = '0;
      chunk_len_addr = '0;
    endfunction

    function logic [15:0] claim_byte();
      claim_byte    = stream_base + stream_offset;
      stream_offset = stream_offset + 16'd1;
    endfunction

    function void stage(logic [15:0] addr, logic [7:0] data, logic we);
      staged.push_back('{addr: addr, data: data, we: we, last: 1'b0});
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      if (index == CFG_MAX_CHUNK_LENGTH) begin
        chunk_limit = value[7:0];
      end else if (index == CFG_BASE_ADDRESS) begin
        stream_base = value[15:0];
      end
    endfunction

    function void note_token(logic [1:0] kind, logic [7:0] lit, logic [15:0] distance,
                             logic [7:0] len);
      int unsigned limit;
      mem_write_t  w;
      limit = (chunk_limit == 8'd0) ? 1 : chunk_limit;
      case (kind)
        OP_LITERAL: begin
          literal_tokens++;
          if (!chunk_active) begin
            if (flag_slot >= TOKENS_PER_FLAG) begin
              flag_addr = claim_byte();
              flag_bits = '0;
              flag_slot = 0;
              stage(flag_addr, 8'h00, 1'b1);
            end
            flag_slot++;
            chunk_len_addr = claim_byte();
            stage(chunk_len_addr, 8'd1, 1'b1);
            stage(claim_byte(), lit, 1'b1);
            chunk_len    = 8'd1;
            chunk_active = (chunk_len < limit);
          end else begin
            stage(claim_byte(), lit, 1'b1);
            chunk_len = chunk_len + 8'd1;
            if (chunk_len >= limit) begin
              stage(chunk_len_addr, chunk_len, 1'b1);
              chunk_active = 1'b0;
            end
          end
        end
        OP_MATCH: begin
          match_tokens++;
          if (chunk_active) begin
            stage(chunk_len_addr, chunk_len, 1'b1);
            chunk_active = 1'b0;
          end
          if (flag_slot >= TOKENS_PER_FLAG) begin
            flag_addr = claim_byte();
            flag_bits = '0;
            flag_slot = 0;
          end
          flag_bits[flag_slot] = 1'b1;
          flag_slot++;
          stage(flag_addr, flag_bits, 1'b1);
          stage(claim_byte(), distance[7:0], 1'b1);
          stage(claim_byte(), distance[15:8], 1'b1);
          stage(claim_byte(), len, 1'b1);
        end
        OP_END: begin
          end_tokens++;
          if (chunk_active) begin
            stage(chunk_len_addr, chunk_len, 1'b1);
          end else begin
            stage(16'h0000, 8'h00, 1'b0);
          end
          restart_stream();
        end
        default: begin
          ignored_tokens++;
        end
      endcase
      foreach (staged[i]) begin
        w      = staged[i];
        w.last = (i == staged.size() - 1);
        expected_writes.push_back(w);
      end
      staged.delete();
    endfunction

    function void check_write(mem_write_t got);
      mem_write_t want;
      writes_checked++;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: write with none expected: addr %h data %h we %b last %b",
                   $time, got.addr, got.data, got.we, got.last);
        end
      end else begin
        want = expected_writes.pop_front();
        if (got.addr !== want.addr || got.data !== want.data ||
            got.we !== want.we || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: write mismatch: expected addr %h data %h we %b last %b,",
                     $time, want.addr, want.data, want.we, want.last,
                     " got addr %h data %h we %b last %b",
                     got.addr, got.data, got.we, got.last);
          end
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_writes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // knobs the stimulus hands to the idling logic of both sides
  bit          source_idle_on   = 1'b1;
  bit          sink_idle_on     = 1'b1;
  int unsigned sink_hold_cycles = 0;
  int unsigned settings_used    = 1;

  write_scoreboard sb = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  lzss_token_serializer_top #(
    .FLAG_BITS     (TOKENS_PER_FLAG),
    .ADDRESS_WIDTH (16)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // monitor: every handshake is sampled at the edge where it completes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_register(cfg_index, cfg_data);
      end
      if (in_tvalid && in_tready) begin
        sb.note_token(in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[31:24]);
      end
      if (out_tvalid && out_tready) begin
        sb.check_write('{addr: out_tdata[15:0], data: out_tdata[23:16],
                         we: out_tuser, last: out_tlast});
      end
    end
  end

  // one token transfer, after a random gap when source idling is on
  task automatic send_token(input logic [1:0] kind, input logic [7:0] lit,
                            input logic [15:0] distance, input logic [7:0] len);
    int unsigned gap;
    gap = source_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {len, distance, lit};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // all fields random, also the ones the opcode does not use
  task automatic send_random(input logic [1:0] kind);
    send_token(kind, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
               8'($urandom_range(0, 255)));
  endtask

  task automatic stop_source();
    in_tvalid <= 1'b0;
  endtask

  // one edge first so the monitor has seen the last token transfer
  task automatic wait_for_drain();
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // both registers back to back, valid stays high between the two transfers
  task automatic program_registers(input logic [7:0] chunk_max, input logic [15:0] base);
    logic [7:0] filler;
    filler    = 8'($urandom_range(0, 255));
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_CHUNK_LENGTH;
    cfg_data  <= {filler, chunk_max};   // upper byte is not part of the register
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_BASE_ADDRESS;
    cfg_data  <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // one register setting and a random token mix: literal runs, matches,
  // end markers and dropped opcodes
  task automatic run_phase(input logic [7:0] chunk_max, input logic [15:0] base,
                           input int unsigned tokens, input bit src_idle, input bit snk_idle,
                           input int unsigned hold, input bit long_run, input bit leave_open);
    int unsigned sent;
    int unsigned run;
    int unsigned cap;
    int unsigned pick;
    program_registers(chunk_max, base);
    source_idle_on   = src_idle;
    sink_idle_on     = snk_idle;
    sink_hold_cycles = hold;
    // literal runs up to two longer than a chunk, at most 12, so small chunks close on their own
    cap = (chunk_max + 2 > 12) ? 12 : chunk_max + 2;
    // a literal first: it grows or closes whatever the last phase left open
    send_random(OP_LITERAL);
    sent = 1;
    while (sent < tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        run = $urandom_range(1, cap);
        repeat (run) send_random(OP_LITERAL);
        sent += run;
      end else if (pick < 80) begin
        send_random(OP_MATCH);
        sent++;
      end else if (pick < 90) begin
        send_random(OP_END);
        sent++;
      end else begin
        send_random(OP_IGNORED);
      end
    end
    // a run long enough to fill the largest chunk and open the next
    if (long_run) begin
      repeat (256) send_random(OP_LITERAL);
    end
    // either leave a chunk open across the next register write or end the stream
    if (leave_open) begin
      repeat (5) send_random(OP_LITERAL);
    end else begin
      send_random(OP_END);
    end
    // sender pauses until every write is out, then the block settles
    stop_source();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall per write, or one long hold-off when asked
  initial begin : result_sink
    int unsigned gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (sink_hold_cycles > 0) begin
        gap              = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // cycle counter as a watchdog
  initial begin : watchdog
    int unsigned elapsed_cycles;
    elapsed_cycles = 0;
    while (elapsed_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      elapsed_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned errors;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed tokens at the reset settings
    send_token(OP_END,     8'h00, 16'h0000, 8'h00);   // end with nothing open
    send_token(OP_IGNORED, 8'hFF, 16'hFFFF, 8'hFF);
    send_token(OP_LITERAL, 8'h00, 16'hFFFF, 8'hFF);
    send_token(OP_LITERAL, 8'hFF, 16'h0000, 8'h00);
    send_token(OP_MATCH,   8'hFF, 16'h0000, 8'h00);   // match closes the open chunk
    send_token(OP_MATCH,   8'h00, 16'hFFFF, 8'hFF);
    send_token(OP_LITERAL, 8'hA5, 16'h5A5A, 8'h3C);
    send_token(OP_IGNORED, 8'h00, 16'h0000, 8'h00);   // dropped inside a chunk
    send_token(OP_END,     8'h5A, 16'hA5A5, 8'hC3);   // end patches the open chunk
    // nine alternating tokens: the ninth reserves a second flag byte
    for (int i = 0; i < 9; i++) begin
      send_random((i % 2 == 0) ? OP_MATCH : OP_LITERAL);
    end
    send_token(OP_END, 8'h00, 16'h0000, 8'h00);
    stop_source();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // largest chunk, filled to the limit, left open into the next phase
    run_phase(8'd255, 16'h0000, 10, 1'b1, 1'b1, 0, 1'b1, 1'b1);
    // limit lowered below the open count, base near the top so addresses wrap
    run_phase(8'd4, 16'hFFFE, 20, 1'b1, 1'b1, 0, 1'b0, 1'b0);
    // limit zero, back-to-back tokens, long receiver hold-off fills the block
    run_phase(8'd0, 16'h8000, 20, 1'b0, 1'b0, LONG_HOLD, 1'b0, 1'b0);
    run_phase(8'd1, 16'hFFFF, 15, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    run_phase(8'd2, 16'($urandom_range(0, 65535)), 20, 1'b0, 1'b1, 0, 1'b0, 1'b1);
    run_phase(8'($urandom_range(3, 254)), 16'($urandom_range(0, 65535)), 25,
              1'b1, 1'b1, 0, 1'b0, 1'b1);
    // base moved under an open chunk: the patch keeps its old address
    run_phase(8'd255, 16'h0000, 15, 1'b0, 1'b0, 0, 1'b0, 1'b0);

    errors = sb.mismatches + sb.outstanding();
    $display("run covered %0d literals, %0d matches, %0d end markers, %0d dropped opcodes",
             sb.literal_tokens, sb.match_tokens, sb.end_tokens, sb.ignored_tokens);
    $display("%0d writes checked over %0d register settings, %0d mismatches, %0d missing",
             sb.writes_checked, settings_used, sb.mismatches, sb.outstanding());
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
